FILE: sv/phcp_pkg.sv
package phcp_pkg;

   // layer codes as they appear on the result channel
   localparam logic [3:0] LAYER_ETH  = 4'd0;
   localparam logic [3:0] LAYER_ARP  = 4'd1;
   localparam logic [3:0] LAYER_ARPB = 4'd2;
   localparam logic [3:0] LAYER_IP4  = 4'd3;
   localparam logic [3:0] LAYER_IP6  = 4'd4;
   localparam logic [3:0] LAYER_ICMP = 4'd5;
   localparam logic [3:0] LAYER_TCP  = 4'd6;
   localparam logic [3:0] LAYER_UDP  = 4'd7;
   localparam logic [3:0] LAYER_PAY  = 4'd8;

   localparam logic [15:0] ETYPE_IPV6       = 16'h86DD;
   localparam logic [15:0] ETYPE_ARP        = 16'h0806;
   localparam logic [15:0] ETYPE_IPV4       = 16'h0800;
   localparam logic [15:0] ARP_HTYPE_ETH    = 16'h0001;
   localparam logic [7:0]  MAC_ADDR_BYTES   = 8'd6;
   localparam logic [7:0]  IPV4_ADDR_BYTES  = 8'd4;
   localparam logic [15:0] PROTO_ICMP       = 16'd1;
   localparam logic [15:0] PROTO_TCP        = 16'd6;
   localparam logic [15:0] PROTO_UDP        = 16'd17;
   localparam logic [15:0] PROTO_IPV6_ENCAP = 16'd41;

   localparam logic [5:0] ETH_HDR_BYTES  = 6'd14;
   localparam logic [5:0] ARP_HDR_BYTES  = 6'd8;
   localparam logic [5:0] IP4_HDR_BYTES  = 6'd20;
   localparam logic [5:0] IP6_HDR_BYTES  = 6'd40;
   localparam logic [5:0] TCP_MIN_BYTES  = 6'd20;
   localparam logic [5:0] UDP_HDR_BYTES  = 6'd8;
   localparam logic [5:0] TCP_MIN_DOFF   = 6'd5;
   localparam logic [5:0] OFFSET_MAX     = 6'd63;

   typedef struct packed {
      logic [15:0] frame_len;
      logic        first_byte;
      logic [7:0]  data_byte;
   } item_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic       bad_tcp_offset;
      logic       layer_end;
      logic [5:0] offset_in_layer;
      logic [3:0] layer;
   } result_type;

   function automatic logic [3:0] proto_next(input logic [15:0] sel);
      logic [3:0] nxt;
      case (sel)
         PROTO_ICMP:       nxt = LAYER_ICMP;
         PROTO_TCP:        nxt = LAYER_TCP;
         PROTO_UDP:        nxt = LAYER_UDP;
         PROTO_IPV6_ENCAP: nxt = LAYER_IP6;
         default:          nxt = LAYER_PAY;
      endcase
      return nxt;
   endfunction

endpackage

FILE: sv/phcp_tracker.sv
module phcp_tracker
   import phcp_pkg::*;
#(
   parameter int ICMP_HEADER_BYTES = 28,
   parameter int ARP_BODY_BYTES    = 20
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  item_type   item,
   output result_type result
);

   localparam logic [5:0] ICMP_LEN = 6'(ICMP_HEADER_BYTES);
   localparam logic [5:0] ARPB_LEN = 6'(ARP_BODY_BYTES);

   logic [3:0]  cur_layer_ff,  cur_layer_in;
   logic [5:0]  layer_off_ff,  layer_off_in;
   logic [5:0]  hdr_len_ff,    hdr_len_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [7:0]  held_ff,       held_in;
   logic [15:0] sel_ff,        sel_in;
   logic        arp_ok_ff,     arp_ok_in;
   logic        tcp_bad_ff,    tcp_bad_in;

   logic [3:0] lay;
   logic [5:0] off;
   logic [3:0] nxt;
   logic [5:0] size;
   logic [3:0] doff;
   logic       end_w;
   logic       bad_w;
   logic [7:0] b;

   assign b = item.data_byte;

   always_comb begin
      cur_layer_in  = cur_layer_ff;
      layer_off_in  = layer_off_ff;
      hdr_len_in    = hdr_len_ff;
      bytes_left_in = bytes_left_ff;
      held_in       = held_ff;
      sel_in        = sel_ff;
      arp_ok_in     = arp_ok_ff;
      tcp_bad_in    = tcp_bad_ff;
      nxt           = LAYER_PAY;
      bad_w         = 1'b0;
      doff          = b[7:4];

      // a first byte drops whatever frame was in progress
      if (item.first_byte) begin
         cur_layer_in  = LAYER_ETH;
         layer_off_in  = 6'd0;
         bytes_left_in = item.frame_len;
         held_in       = 8'd0;
         sel_in        = 16'd0;
         arp_ok_in     = 1'b0;
         tcp_bad_in    = 1'b0;
      end

      case (cur_layer_in)
         LAYER_ETH:  size = ETH_HDR_BYTES;
         LAYER_ARP:  size = ARP_HDR_BYTES;
         LAYER_ARPB: size = ARPB_LEN;
         LAYER_IP4:  size = IP4_HDR_BYTES;
         LAYER_IP6:  size = IP6_HDR_BYTES;
         LAYER_ICMP: size = ICMP_LEN;
         LAYER_TCP:  size = TCP_MIN_BYTES;
         LAYER_UDP:  size = UDP_HDR_BYTES;
         default:    size = 6'd0;
      endcase

      if (bytes_left_in == 16'd0) begin
         if (cur_layer_in != LAYER_PAY) begin
            cur_layer_in = LAYER_PAY;
            layer_off_in = 6'd0;
         end
      end else if (cur_layer_in != LAYER_PAY && layer_off_in == 6'd0) begin
         // header that does not fit falls through to payload
         if (bytes_left_in < {10'd0, size}) begin
            cur_layer_in = LAYER_PAY;
         end else begin
            hdr_len_in = size;
            tcp_bad_in = 1'b0;
         end
      end

      lay = cur_layer_in;
      off = layer_off_in;

      case (lay)
         LAYER_ETH: begin
            if (off == 6'd12) held_in = b;
            else if (off == 6'd13) sel_in = {held_in, b};
            if (sel_in == ETYPE_IPV6) nxt = LAYER_IP6;
            else if (sel_in == ETYPE_ARP) nxt = LAYER_ARP;
            else if (sel_in == ETYPE_IPV4) nxt = LAYER_IP4;
         end
         LAYER_ARP: begin
            if (off == 6'd0 || off == 6'd2) held_in = b;
            else if (off == 6'd1) arp_ok_in = ({held_in, b} == ARP_HTYPE_ETH);
            else if (off == 6'd3) arp_ok_in = arp_ok_in && ({held_in, b} == ETYPE_IPV4);
            else if (off == 6'd4) arp_ok_in = arp_ok_in && (b == MAC_ADDR_BYTES);
            else if (off == 6'd5) arp_ok_in = arp_ok_in && (b == IPV4_ADDR_BYTES);
            nxt = arp_ok_in ? LAYER_ARPB : LAYER_PAY;
         end
         LAYER_IP4: begin
            if (off == 6'd9) sel_in = {8'd0, b};
            nxt = proto_next(sel_in);
         end
         LAYER_IP6: begin
            if (off == 6'd6) sel_in = {8'd0, b};
            nxt = proto_next(sel_in);
         end
         LAYER_TCP: begin
            if (off == 6'd12) begin
               if ({2'd0, doff} < TCP_MIN_DOFF) begin
                  hdr_len_in = TCP_MIN_BYTES;
                  tcp_bad_in = 1'b1;
               end else begin
                  hdr_len_in = {doff, 2'b00};
               end
            end
            bad_w = tcp_bad_in;
         end
         default: begin
         end
      endcase

      end_w = (lay != LAYER_PAY) && (({1'b0, off} + 7'd1) == {1'b0, hdr_len_in});

      if (end_w) begin
         cur_layer_in = nxt;
         layer_off_in = 6'd0;
      end else begin
         layer_off_in = (off < OFFSET_MAX) ? off + 6'd1 : OFFSET_MAX;
      end

      if (bytes_left_in != 16'd0) bytes_left_in = bytes_left_in - 16'd1;
   end

   assign result.layer           = lay;
   assign result.offset_in_layer = off;
   assign result.layer_end       = end_w;
   assign result.bad_tcp_offset  = bad_w;
   assign result.byte_out        = b;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_layer_ff  <= LAYER_PAY;
         layer_off_ff  <= 6'd0;
         hdr_len_ff    <= 6'd0;
         bytes_left_ff <= 16'd0;
         held_ff       <= 8'd0;
         sel_ff        <= 16'd0;
         arp_ok_ff     <= 1'b0;
         tcp_bad_ff    <= 1'b0;
      end else if (step) begin
         cur_layer_ff  <= cur_layer_in;
         layer_off_ff  <= layer_off_in;
         hdr_len_ff    <= hdr_len_in;
         bytes_left_ff <= bytes_left_in;
         held_ff       <= held_in;
         sel_ff        <= sel_in;
         arp_ok_ff     <= arp_ok_in;
         tcp_bad_ff    <= tcp_bad_in;
      end
   end

endmodule

FILE: sv/packet_header_chain_parser_core.sv
// Path: input register, then result register; a held byte moves to the result register
//   when that register is empty or being read.
// Throughput: one byte per cycle unless rsp_tready stalls; next state is combinational.
// Reset: synchronous, active high; empties both registers and returns the tracker to the
//   payload layer, waiting for a first byte.
module packet_header_chain_parser_core
   import phcp_pkg::*;
#(
   parameter int ICMP_HEADER_BYTES = 28,
   parameter int ARP_BODY_BYTES    = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // data_byte[7:0], frame_len[23:8]
   input  logic        req_tuser,  // first_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // layer[3:0], offset_in_layer[9:4], byte_out[17:10], zero
   output logic        rsp_tlast,  // layer_end
   output logic        rsp_tuser   // bad_tcp_offset
);

   item_type   item_ff, item_in;
   logic       in_valid_ff, in_valid_in;
   result_type out_ff;
   logic       out_valid_ff, out_valid_in;
   result_type result;
   logic       step;
   logic       req_take;

   assign step     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;
   assign req_take = req_tvalid && req_tready;

   assign item_in.data_byte  = req_tdata[7:0];
   assign item_in.frame_len  = req_tdata[23:8];
   assign item_in.first_byte = req_tuser;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) in_valid_in = 1'b1;
      else if (step) in_valid_in = 1'b0;
      out_valid_in = out_valid_ff;
      if (step) out_valid_in = 1'b1;
      else if (rsp_tready) out_valid_in = 1'b0;
   end

   phcp_tracker #(
      .ICMP_HEADER_BYTES (ICMP_HEADER_BYTES),
      .ARP_BODY_BYTES    (ARP_BODY_BYTES)
   ) u_tracker (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers: load on transaction, hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) item_ff <= item_in;
      if (step) out_ff <= result;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_ff.byte_out, out_ff.offset_in_layer, out_ff.layer};
   assign rsp_tlast  = out_ff.layer_end;
   assign rsp_tuser  = out_ff.bad_tcp_offset;

`ifndef SYNTHESIS
   a_pay_no_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_ff.layer == LAYER_PAY |-> !rsp_tlast)
      else $error("layer end flagged on payload byte");

   a_bad_only_tcp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> out_ff.layer == LAYER_TCP)
      else $error("bad tcp offset flagged outside tcp");

   a_first_starts: assert property (@(posedge clock) disable iff (reset)
      step && item_ff.first_byte |=> out_ff.offset_in_layer == 6'd0 &&
         (out_ff.layer == LAYER_ETH || out_ff.layer == LAYER_PAY))
      else $error("first byte did not restart the frame");

   a_hdr_off_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_ff.layer != LAYER_PAY |-> out_ff.offset_in_layer != OFFSET_MAX)
      else $error("header offset out of range");
`endif

endmodule

FILE: tb/tb_packet_header_chain_parser_core.sv
module tb_packet_header_chain_parser_core;
   import phcp_pkg::*;

   localparam int ICMP_BYTES   = 28;
   localparam int ARPB_BYTES   = 20;
   localparam int RANDOM_BYTES = 1300;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int REPORT_MAX   = 10;

   typedef struct {
      logic [7:0]  data;
      logic        lead;
      logic [15:0] flen;
      logic        typed;
      result_type  want;
   } stim_row_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;  // data_byte[7:0], frame_len[23:8]
   logic        req_tuser  = 1'b0;  // first_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;  // layer[3:0], offset_in_layer[9:4], byte_out[17:10], zero
   logic        rsp_tlast;  // layer_end
   logic        rsp_tuser;  // bad_tcp_offset

   // header tracker mirror
   logic [3:0]  trk_layer   = LAYER_PAY;
   logic [5:0]  trk_off     = '0;
   logic [5:0]  trk_hdr_len = '0;
   logic [15:0] trk_left    = '0;
   logic [7:0]  trk_held    = '0;
   logic [15:0] trk_sel     = '0;
   logic        trk_arp_ok  = 1'b0;
   logic        trk_tcp_bad = 1'b0;

   result_type   byte_labels[$];
   stim_row_type dir_rows[$];
   logic [7:0]   frame_bytes[$];

   int burst_left      = 0;
   int bytes_sent      = 0;
   int frames_sent     = 0;
   int results_checked = 0;
   int errors          = 0;
   int short_doff_hits = 0;
   int layer_hits[0:8];
   int cycles;

   packet_header_chain_parser_core #(
      .ICMP_HEADER_BYTES(ICMP_BYTES),
      .ARP_BODY_BYTES   (ARPB_BYTES)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [6:0] hdr_size(input logic [3:0] lay);
      case (lay)
         LAYER_ETH:  return 7'(ETH_HDR_BYTES);
         LAYER_ARP:  return 7'(ARP_HDR_BYTES);
         LAYER_ARPB: return 7'(ARPB_BYTES);
         LAYER_IP4:  return 7'(IP4_HDR_BYTES);
         LAYER_IP6:  return 7'(IP6_HDR_BYTES);
         LAYER_ICMP: return 7'(ICMP_BYTES);
         LAYER_TCP:  return 7'(TCP_MIN_BYTES);
         LAYER_UDP:  return 7'(UDP_HDR_BYTES);
         default:    return 7'd0;
      endcase
   endfunction

   function automatic logic [3:0] ip_next_layer(input logic [15:0] sel);
      case (sel)
         PROTO_ICMP:       return LAYER_ICMP;
         PROTO_TCP:        return LAYER_TCP;
         PROTO_UDP:        return LAYER_UDP;
         PROTO_IPV6_ENCAP: return LAYER_IP6;
         default:          return LAYER_PAY;
      endcase
   endfunction

   // label one byte and advance the tracker
   function automatic result_type label_byte(input logic [7:0] b, input logic lead,
                                             input logic [15:0] flen);
      result_type r;
      logic [3:0] lay;
      logic [3:0] nxt;
      logic [3:0] doff;
      logic [5:0] off;
      logic [6:0] sz;
      logic       closes;
      logic       bad;
      nxt    = LAYER_PAY;
      closes = 1'b0;
      bad    = 1'b0;
      if (lead) begin
         trk_layer   = LAYER_ETH;
         trk_off     = '0;
         trk_left    = flen;
         trk_held    = '0;
         trk_sel     = '0;
         trk_arp_ok  = 1'b0;
         trk_tcp_bad = 1'b0;
      end
      sz = hdr_size(trk_layer);
      if (trk_left == 0) begin
         if (trk_layer != LAYER_PAY) begin
            trk_layer = LAYER_PAY;
            trk_off   = '0;
         end
      end else if (trk_layer != LAYER_PAY && trk_off == 0) begin
         // header must fit in what is left, current byte included
         if (trk_left < 16'(sz)) begin
            trk_layer = LAYER_PAY;
         end else begin
            trk_hdr_len = sz[5:0];
            trk_tcp_bad = 1'b0;
         end
      end
      lay = trk_layer;
      off = trk_off;
      case (lay)
         LAYER_ETH: begin
            if (off == 6'd12) trk_held = b;
            else if (off == 6'd13) trk_sel = {trk_held, b};
            if (trk_sel == ETYPE_IPV6) nxt = LAYER_IP6;
            else if (trk_sel == ETYPE_ARP) nxt = LAYER_ARP;
            else if (trk_sel == ETYPE_IPV4) nxt = LAYER_IP4;
         end
         LAYER_ARP: begin
            if (off == 6'd0 || off == 6'd2) trk_held = b;
            else if (off == 6'd1) trk_arp_ok = ({trk_held, b} == ARP_HTYPE_ETH);
            else if (off == 6'd3) trk_arp_ok = trk_arp_ok && ({trk_held, b} == ETYPE_IPV4);
            else if (off == 6'd4) trk_arp_ok = trk_arp_ok && (b == MAC_ADDR_BYTES);
            else if (off == 6'd5) trk_arp_ok = trk_arp_ok && (b == IPV4_ADDR_BYTES);
            nxt = trk_arp_ok ? LAYER_ARPB : LAYER_PAY;
         end
         LAYER_IP4: begin
            if (off == 6'd9) trk_sel = {8'd0, b};
            nxt = ip_next_layer(trk_sel);
         end
         LAYER_IP6: begin
            if (off == 6'd6) trk_sel = {8'd0, b};
            nxt = ip_next_layer(trk_sel);
         end
         LAYER_TCP: begin
            if (off == 6'd12) begin
               doff = b[7:4];
               if ({2'b00, doff} < TCP_MIN_DOFF) begin
                  trk_hdr_len = TCP_MIN_BYTES;
                  trk_tcp_bad = 1'b1;
               end else begin
                  trk_hdr_len = {doff, 2'b00};
               end
            end
            bad = trk_tcp_bad;
         end
         default: ;
      endcase
      if (lay != LAYER_PAY && {1'b0, off} + 7'd1 == {1'b0, trk_hdr_len}) begin
         closes    = 1'b1;
         trk_layer = nxt;
         trk_off   = '0;
      end else begin
         trk_off = (off < OFFSET_MAX) ? off + 6'd1 : OFFSET_MAX;
      end
      if (trk_left != 0) trk_left = trk_left - 16'd1;
      r.layer           = lay;
      r.offset_in_layer = off;
      r.layer_end       = closes;
      r.bad_tcp_offset  = bad;
      r.byte_out        = b;
      return r;
   endfunction

   // drive one byte in bursts with random gaps, hold until accepted
   task automatic send_byte(input logic [7:0] d, input logic lead, input logic [15:0] flen,
                            input logic typed, input result_type want);
      int gap;
      result_type r;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {flen, d};
      req_tuser  <= lead;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = label_byte(d, lead, flen);
      byte_labels.push_back(typed ? want : r);
      bytes_sent++;
   endtask

   task automatic add_row(input logic [7:0] d, input logic lead, input logic [15:0] flen,
                          input logic typed, input logic [3:0] lay, input logic [5:0] off,
                          input logic closes);
      stim_row_type s;
      s.data  = d;
      s.lead  = lead;
      s.flen  = flen;
      s.typed = typed;
      s.want  = '{byte_out: d, bad_tcp_offset: 1'b0, layer_end: closes,
                  offset_in_layer: off, layer: lay};
      dir_rows.push_back(s);
   endtask

   task automatic add_random(input int n);
      repeat (n) frame_bytes.push_back(8'($urandom));
   endtask

   // mostly well-formed header chain with random content, then payload
   task automatic build_frame();
      logic [3:0]  lay;
      logic [3:0]  nxt;
      logic [3:0]  doff;
      logic [15:0] etype;
      logic [7:0]  proto;
      int hops;
      int base;
      frame_bytes.delete();
      add_random(12);
      case ($urandom_range(0, 9))
         0, 1, 2: begin etype = ETYPE_IPV4;    lay = LAYER_IP4; end
         3, 4, 5: begin etype = ETYPE_IPV6;    lay = LAYER_IP6; end
         6, 7:    begin etype = ETYPE_ARP;     lay = LAYER_ARP; end
         default: begin etype = 16'($urandom); lay = LAYER_PAY; end
      endcase
      frame_bytes.push_back(etype[15:8]);
      frame_bytes.push_back(etype[7:0]);
      hops = 0;
      while (lay != LAYER_PAY) begin
         base = frame_bytes.size();
         hops++;
         case (lay)
            LAYER_ARP: begin
               add_random(8);
               frame_bytes[base + 0] = ARP_HTYPE_ETH[15:8];
               frame_bytes[base + 1] = ARP_HTYPE_ETH[7:0];
               frame_bytes[base + 2] = ETYPE_IPV4[15:8];
               frame_bytes[base + 3] = ETYPE_IPV4[7:0];
               frame_bytes[base + 4] = MAC_ADDR_BYTES;
               frame_bytes[base + 5] = IPV4_ADDR_BYTES;
               lay = LAYER_ARPB;
               // break one field of the ARP form now and then
               if ($urandom_range(0, 4) == 0) begin
                  frame_bytes[base + $urandom_range(0, 5)] = 8'($urandom);
                  lay = LAYER_PAY;
               end
            end
            LAYER_ARPB: begin
               add_random(ARPB_BYTES);
               lay = LAYER_PAY;
            end
            LAYER_IP4, LAYER_IP6: begin
               add_random(lay == LAYER_IP4 ? 20 : 40);
               case ($urandom_range(0, 9))
                  0, 1, 2: begin proto = PROTO_TCP[7:0];  nxt = LAYER_TCP;  end
                  3, 4:    begin proto = PROTO_UDP[7:0];  nxt = LAYER_UDP;  end
                  5:       begin proto = PROTO_ICMP[7:0]; nxt = LAYER_ICMP; end
                  6: begin
                     if (hops < 3) begin
                        proto = PROTO_IPV6_ENCAP[7:0];
                        nxt   = LAYER_IP6;
                     end else begin
                        proto = PROTO_TCP[7:0];
                        nxt   = LAYER_TCP;
                     end
                  end
                  default: begin proto = 8'($urandom); nxt = LAYER_PAY; end
               endcase
               frame_bytes[base + ((lay == LAYER_IP4) ? 9 : 6)] = proto;
               lay = nxt;
            end
            LAYER_ICMP: begin
               add_random(ICMP_BYTES);
               lay = LAYER_PAY;
            end
            LAYER_UDP: begin
               add_random(8);
               lay = LAYER_PAY;
            end
            LAYER_TCP: begin
               doff = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 4))
                                                   : 4'($urandom_range(5, 15));
               add_random((doff < 5) ? 20 : doff * 4);
               frame_bytes[base + 12] = {doff, 4'($urandom)};
               lay = LAYER_PAY;
            end
            default: lay = LAYER_PAY;
         endcase
      end
      add_random(($urandom_range(0, 7) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 16));
   endtask

   // receiver: ready stretches broken by short stalls
   initial begin
      int hi;
      int lo;
      while (reset) @(posedge clock);
      forever begin
         hi = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 20);
         lo = $urandom_range(0, 6);
         rsp_tready <= 1'b1;
         repeat (hi) @(posedge clock);
         if (lo != 0) begin
            rsp_tready <= 1'b0;
            repeat (lo) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : check_results
      result_type seen;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = {rsp_tdata[17:10], rsp_tuser, rsp_tlast, rsp_tdata[9:4], rsp_tdata[3:0]};
         if (byte_labels.size() == 0) begin
            errors++;
            if (errors <= REPORT_MAX)
               $display("unexpected rsp transaction: layer=%0d off=%0d end=%b bad=%b byte=%h",
                        seen.layer, seen.offset_in_layer, seen.layer_end,
                        seen.bad_tcp_offset, seen.byte_out);
         end else begin
            want = byte_labels.pop_front();
            results_checked++;
            if (want.layer <= LAYER_PAY) layer_hits[want.layer]++;
            if (want.bad_tcp_offset) short_doff_hits++;
            if (seen != want || rsp_tdata[23:18] != 6'd0) begin
               errors++;
               if (errors <= REPORT_MAX)
                  $display({"mismatch on result %0d: exp layer=%0d off=%0d end=%b bad=%b ",
                            "byte=%h, got layer=%0d off=%0d end=%b bad=%b byte=%h pad=%h"},
                           results_checked, want.layer, want.offset_in_layer,
                           want.layer_end, want.bad_tcp_offset, want.byte_out,
                           seen.layer, seen.offset_in_layer, seen.layer_end,
                           seen.bad_tcp_offset, seen.byte_out, rsp_tdata[23:18]);
            end
         end
      end
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb_packet_header_chain_parser_core: done, errors");
      $finish;
   end

   initial begin
      logic [15:0] flen;
      int need;
      int n_send;
      foreach (layer_hits[k]) layer_hits[k] = 0;

      // bytes before any frame, then a zero-length frame and a byte past its end
      add_row(8'h00, 1'b0, 16'h0000, 1'b1, LAYER_PAY, 6'd0, 1'b0);
      add_row(8'hFF, 1'b0, 16'hFFFF, 1'b1, LAYER_PAY, 6'd1, 1'b0);
      add_row(8'hA5, 1'b1, 16'h0000, 1'b1, LAYER_PAY, 6'd0, 1'b0);
      add_row(8'h3C, 1'b0, 16'h0000, 1'b1, LAYER_PAY, 6'd1, 1'b0);
      // Ethernet header does not fit
      add_row(8'h5A, 1'b1, 16'd13,   1'b1, LAYER_PAY, 6'd0, 1'b0);
      // longest frame, cut short by a new first byte
      add_row(8'hFF, 1'b1, 16'hFFFF, 1'b1, LAYER_ETH, 6'd0, 1'b0);
      add_row(8'h00, 1'b0, 16'hFFFF, 1'b1, LAYER_ETH, 6'd1, 1'b0);
      // 14-byte frame carrying IPv4: the IPv4 header lands past the frame end
      add_row(8'h11, 1'b1, 16'd14,   1'b1, LAYER_ETH, 6'd0, 1'b0);
      for (int i = 1; i < 12; i++) add_row(8'(i * 23), 1'b0, 16'(i * 4099), 1'b0,
                                           LAYER_ETH, 6'(i), 1'b0);
      add_row(ETYPE_IPV4[15:8], 1'b0, 16'h0000, 1'b0, LAYER_ETH, 6'd12, 1'b0);
      add_row(ETYPE_IPV4[7:0],  1'b0, 16'h0000, 1'b1, LAYER_ETH, 6'd13, 1'b1);
      add_row(8'h45,            1'b0, 16'h0000, 1'b1, LAYER_PAY, 6'd0,  1'b0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_byte(dir_rows[i].data, dir_rows[i].lead, dir_rows[i].flen,
                   dir_rows[i].typed, dir_rows[i].want);

      while (bytes_sent < dir_rows.size() + RANDOM_BYTES) begin
         if ($urandom_range(0, 11) == 0) begin
            // noise: random bytes with stray first-byte marks
            repeat ($urandom_range(1, 12))
               send_byte(8'($urandom), $urandom_range(0, 3) == 0, 16'($urandom), 1'b0, '0);
         end else begin
            build_frame();
            need = frame_bytes.size();
            case ($urandom_range(0, 19))
               0, 1:    flen = 16'($urandom_range(0, need - 1));
               2:       flen = 16'(need + $urandom_range(1, 40));
               3:       flen = 16'hFFFF;
               4:       flen = 16'($urandom);
               default: flen = 16'(need);
            endcase
            n_send = ($urandom_range(0, 9) == 0) ? $urandom_range(1, need) : need;
            for (int i = 0; i < n_send; i++)
               send_byte(frame_bytes[i], i == 0, (i == 0) ? flen : 16'($urandom), 1'b0, '0);
            if ($urandom_range(0, 7) == 0)
               repeat ($urandom_range(1, 6))
                  send_byte(8'($urandom), 1'b0, 16'($urandom), 1'b0, '0);
            frames_sent++;
         end
      end
      req_tvalid <= 1'b0;

      while (byte_labels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d bytes in %0d random frames, %0d results checked, %0d on short TCP offsets",
               bytes_sent, frames_sent, results_checked, short_doff_hits);
      $display({"bytes per layer eth/arp/arpb/ip4/ip6/icmp/tcp/udp/pay: ",
                "%0d %0d %0d %0d %0d %0d %0d %0d %0d"},
               layer_hits[0], layer_hits[1], layer_hits[2], layer_hits[3], layer_hits[4],
               layer_hits[5], layer_hits[6], layer_hits[7], layer_hits[8]);
      if (errors == 0 && byte_labels.size() == 0) begin
         $display("tb_packet_header_chain_parser_core: done, clean");
      end else begin
         $display("tb_packet_header_chain_parser_core: done, errors");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/phcp_pkg.sv
sv/phcp_tracker.sv
sv/packet_header_chain_parser_core.sv
tb/tb_packet_header_chain_parser_core.sv
